@@ design/qrdft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrdft_pkg
// Shared types, constants and tables for the quarter-rate single-bin DFT.
// ----------------------------------------------------------------------------
package qrdft_pkg;

  localparam int ADC_BITS_DEF     = 12;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 24;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 20;
  localparam int ACC_W      = 21;
  localparam int MAG_W      = 12;
  localparam int PHASE_W    = 9;
  localparam int WLEN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CNT_W      = 5;
  localparam int SQ_W       = 2 * SUM_W;
  localparam int SQRT_STEPS = SUM_W;
  localparam int CORD_W     = 48;
  localparam int PRESCALE_SH = 26;
  localparam int ANG_W      = 24;
  localparam int ATAN_W     = 22;

  // degrees in Q16
  localparam logic [ANG_W-1:0] ANG_45  = 24'd2949120;
  localparam logic [ANG_W-1:0] ANG_90  = 24'd5898240;
  localparam logic [ANG_W-1:0] ANG_180 = 24'd11796480;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_MID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_RE0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_IM1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_RE2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_IM3 = 3'd5;

  localparam logic [1:0] COEF_ZERO = 2'b00;
  localparam logic [1:0] COEF_POS  = 2'b01;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_CORDIC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             sq_re;
    logic             sq_im;
    logic             init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             cor_step;
    logic             finish;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic win_close;
    logic out_free;
  } status_t;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [CNT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/qrdft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrdft_ctrl
// Sequencer: sample intake, squaring, root, divide, CORDIC and result load.
// ----------------------------------------------------------------------------
module qrdft_ctrl #(
  parameter int CORDIC_STEPS = qrdft_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qrdft_pkg::status_t  status,
  output qrdft_pkg::cmd_t     cmd
);

  localparam int COR_N = (CORDIC_STEPS > qrdft_pkg::CORDIC_MAX_STEPS) ?
                         qrdft_pkg::CORDIC_MAX_STEPS : CORDIC_STEPS;
  localparam logic [qrdft_pkg::CNT_W-1:0] COR_LAST  = qrdft_pkg::CNT_W'(COR_N - 1);
  localparam logic [qrdft_pkg::CNT_W-1:0] SQRT_LAST =
    qrdft_pkg::CNT_W'(qrdft_pkg::SQRT_STEPS - 1);

  qrdft_pkg::state_t            state_r, state_nxt;
  logic [qrdft_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrdft_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_stall  = 1'b1;
    unique case (state_r)
      qrdft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.win_close) state_nxt = qrdft_pkg::ST_SQ_RE;
        end
      end
      qrdft_pkg::ST_SQ_RE: begin
        cmd.sq_re = 1'b1;
        state_nxt = qrdft_pkg::ST_SQ_IM;
      end
      qrdft_pkg::ST_SQ_IM: begin
        cmd.sq_im = 1'b1;
        state_nxt = qrdft_pkg::ST_INIT;
      end
      qrdft_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = qrdft_pkg::ST_SQRT;
      end
      qrdft_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) state_nxt = qrdft_pkg::ST_DIV_INIT;
      end
      qrdft_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = qrdft_pkg::ST_DIV;
      end
      qrdft_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = qrdft_pkg::ST_CORDIC;
        end
      end
      qrdft_pkg::ST_CORDIC: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == COR_LAST) state_nxt = qrdft_pkg::ST_FINISH;
      end
      qrdft_pkg::ST_FINISH: begin
        // wait here until the output word register can take the result
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = qrdft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qrdft_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/qrdft_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrdft_dp
// Datapath: config registers, accumulators, squarer, root, divider, CORDIC.
// ----------------------------------------------------------------------------
module qrdft_dp #(
  parameter int ADC_BITS = qrdft_pkg::ADC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [qrdft_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qrdft_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [qrdft_pkg::SAMPLE_W-1:0]         in_sample,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [qrdft_pkg::SUM_W-1:0]     out_real_sum,
  output logic signed [qrdft_pkg::SUM_W-1:0]     out_imag_sum,
  output logic [qrdft_pkg::MAG_W-1:0]            out_magnitude,
  output logic signed [qrdft_pkg::PHASE_W-1:0]   out_phase_degrees,
  input  qrdft_pkg::cmd_t                        cmd,
  output qrdft_pkg::status_t                     status
);

  localparam int SW = qrdft_pkg::SUM_W;
  localparam int AW = qrdft_pkg::ACC_W;
  localparam int CW = qrdft_pkg::CORD_W;
  localparam int GW = qrdft_pkg::ANG_W;
  localparam logic signed [AW-1:0] SUM_MAX = AW'((1 << (SW - 1)) - 1);
  localparam logic signed [AW-1:0] SUM_MIN = -AW'(1 << (SW - 1));
  localparam logic signed [GW-1:0] Z_LO = GW'(1);
  localparam logic signed [GW-1:0] Z_HI = GW'(2949119);

  // configuration
  logic [11:0] mid_r;
  logic [7:0]  wlen_r;
  logic [1:0]  coef_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r     <= 12'd2048;
      wlen_r    <= 8'd64;
      coef_r[0] <= 2'b01;
      coef_r[1] <= 2'b01;
      coef_r[2] <= 2'b11;
      coef_r[3] <= 2'b11;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qrdft_pkg::REG_ADC_MID:  mid_r     <= cfg_wdata;
        qrdft_pkg::REG_WIN_LEN:  wlen_r    <= cfg_wdata[7:0];
        qrdft_pkg::REG_COEF_RE0: coef_r[0] <= cfg_wdata[1:0];
        qrdft_pkg::REG_COEF_IM1: coef_r[1] <= cfg_wdata[1:0];
        qrdft_pkg::REG_COEF_RE2: coef_r[2] <= cfg_wdata[1:0];
        qrdft_pkg::REG_COEF_IM3: coef_r[3] <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // accumulation
  logic [7:0]              idx_r, idx_inc;
  logic signed [AW-1:0]    re_acc_r, im_acc_r, re_acc_nxt, im_acc_nxt;
  logic signed [SW-1:0]    re_r, im_r;
  logic [11:0]             smp_m;
  logic signed [12:0]      x_s, term;
  logic [1:0]              cv;
  logic [7:0]              wl_eff;

  function automatic logic signed [SW-1:0] sat_sum(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SUM_MAX)      r = SUM_MAX[SW-1:0];
    else if (v < SUM_MIN) r = SUM_MIN[SW-1:0];
    else                  r = v[SW-1:0];
    return r;
  endfunction

  always_comb begin
    for (int j = 0; j < 12; j++) smp_m[j] = (j < ADC_BITS) ? in_sample[j] : 1'b0;
    x_s     = $signed({1'b0, smp_m}) - $signed({1'b0, mid_r});
    cv      = coef_r[idx_r[1:0]];
    case (cv)
      qrdft_pkg::COEF_POS:  term = x_s;
      qrdft_pkg::COEF_ZERO: term = '0;
      default:              term = -x_s;
    endcase
    re_acc_nxt = re_acc_r;
    im_acc_nxt = im_acc_r;
    if (idx_r[0]) im_acc_nxt = im_acc_r - AW'(term);
    else          re_acc_nxt = re_acc_r + AW'(term);
    wl_eff  = (wlen_r == 8'd0) ? 8'd1 : wlen_r;
    idx_inc = idx_r + 8'd1;
  end

  assign status.win_close = (idx_inc >= wl_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      re_acc_r <= '0;
      im_acc_r <= '0;
    end else if (cmd.accept) begin
      if (status.win_close) begin
        idx_r    <= '0;
        re_acc_r <= '0;
        im_acc_r <= '0;
      end else begin
        idx_r    <= idx_inc;
        re_acc_r <= re_acc_nxt;
        im_acc_r <= im_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.win_close) begin
      re_r <= sat_sum(re_acc_nxt);
      im_r <= sat_sum(im_acc_nxt);
    end
  end

  // squares, root, divide
  logic [qrdft_pkg::SQ_W-1:0] p_r, q_r, rad_r;
  logic [SW:0]                rem_r;
  logic [SW-1:0]              root_r, quo_r;
  logic [7:0]                 drem_r;
  logic [SW+2:0]              rem_t, trial;
  logic [8:0]                 drem_t;
  logic signed [2*SW-1:0]     prod;

  always_comb begin
    prod   = cmd.sq_re ? re_r * re_r : im_r * im_r;
    rem_t  = {rem_r, rad_r[qrdft_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    drem_t = {drem_r, quo_r[SW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_re) p_r <= $unsigned(prod);
    if (cmd.sq_im) q_r <= $unsigned(prod);
    if (cmd.init) begin
      rad_r  <= p_r + q_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[qrdft_pkg::SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= (SW+1)'(rem_t - trial);
        root_r <= {root_r[SW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[SW:0];
        root_r <= {root_r[SW-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      quo_r  <= root_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (drem_t >= {1'b0, wl_eff}) begin
        drem_r <= 8'(drem_t - {1'b0, wl_eff});
        quo_r  <= {quo_r[SW-2:0], 1'b1};
      end else begin
        drem_r <= drem_t[7:0];
        quo_r  <= {quo_r[SW-2:0], 1'b0};
      end
    end
  end

  // CORDIC vectoring on the folded octant
  logic [SW-1:0]         ax, ay, big, lesser;
  logic signed [CW-1:0]  x_r, y_r, dx, dy;
  logic signed [GW-1:0]  z_r, atan_s;
  logic                  im_zero_r, re_neg_r, im_neg_r, swap_r, small0_r, equal_r;

  always_comb begin
    ax     = re_r[SW-1] ? (~re_r + 1'b1) : re_r;
    ay     = im_r[SW-1] ? (~im_r + 1'b1) : im_r;
    big    = (ax > ay) ? ax : ay;
    lesser = (ax > ay) ? ay : ax;
    dx     = y_r >>> cmd.idx;
    dy     = x_r >>> cmd.idx;
    atan_s = $signed(GW'(qrdft_pkg::atan_deg(cmd.idx)));
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r       <= $signed(CW'({big, {qrdft_pkg::PRESCALE_SH{1'b0}}}));
      y_r       <= $signed(CW'({lesser, {qrdft_pkg::PRESCALE_SH{1'b0}}}));
      z_r       <= '0;
      im_zero_r <= (im_r == '0);
      re_neg_r  <= re_r[SW-1];
      im_neg_r  <= im_r[SW-1];
      swap_r    <= (ay > ax);
      small0_r  <= (lesser == '0);
      equal_r   <= (lesser == big);
    end else if (cmd.cor_step) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_s;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_s;
      end
    end
  end

  // result assembly
  logic signed [GW-1:0]             zc;
  logic [GW-1:0]                    a0, a1, a2;
  logic [7:0]                       deg;
  logic signed [qrdft_pkg::PHASE_W-1:0] phase;
  logic [qrdft_pkg::MAG_W-1:0]      mag;

  always_comb begin
    zc  = (z_r < Z_LO) ? Z_LO : ((z_r > Z_HI) ? Z_HI : z_r);
    a0  = small0_r ? '0 : (equal_r ? qrdft_pkg::ANG_45 : $unsigned(zc));
    a1  = swap_r   ? qrdft_pkg::ANG_90 - a0 : a0;
    a2  = re_neg_r ? qrdft_pkg::ANG_180 - a1 : a1;
    deg = a2[GW-1:16];
    if (im_zero_r)
      phase = re_neg_r ? 9'sd180 : 9'sd0;
    else if (im_neg_r)
      phase = -$signed({1'b0, deg});
    else
      phase = $signed({1'b0, deg});
    mag = (quo_r > SW'(4095)) ? 12'd4095 : quo_r[11:0];
  end

  logic out_valid_r;
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_real_sum      <= re_r;
      out_imag_sum      <= im_r;
      out_magnitude     <= mag;
      out_phase_degrees <= phase;
    end
  end

endmodule

@@ design/quarter_rate_single_bin_dft.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_rate_single_bin_dft
// Single-bin DFT at fs/4 with magnitude (integer root) and CORDIC phase.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_sample           | sample words in
//  out     | out_valid, out_stall, out_real_sum,     | one word per window
//          | out_imag_sum, out_magnitude,            |
//          | out_phase_degrees                       |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register writes
//
// A sample that does not close a window is only accumulated. A closing sample
// starts two squares, a 20-step root, a 20-step divide by window_len and a
// CORDIC loop of min(CORDIC_STEPS,24) steps, each on one shared unit, one step
// a cycle.
// Synchronous active-low reset clears the sequencer, index and accumulators.
// A held output word stalls the sequencer only at the final load.
// ----------------------------------------------------------------------------
module quarter_rate_single_bin_dft #(
  parameter int ADC_BITS     = qrdft_pkg::ADC_BITS_DEF,
  parameter int CORDIC_STEPS = qrdft_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [qrdft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrdft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [qrdft_pkg::SAMPLE_W-1:0]        in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qrdft_pkg::SUM_W-1:0]    out_real_sum,
  output logic signed [qrdft_pkg::SUM_W-1:0]    out_imag_sum,
  output logic [qrdft_pkg::MAG_W-1:0]           out_magnitude,
  output logic signed [qrdft_pkg::PHASE_W-1:0]  out_phase_degrees
);

  qrdft_pkg::cmd_t    cmd;
  qrdft_pkg::status_t status;

  qrdft_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  qrdft_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sample         (in_sample),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_real_sum      (out_real_sum),
    .out_imag_sum      (out_imag_sum),
    .out_magnitude     (out_magnitude),
    .out_phase_degrees (out_phase_degrees),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
